// ===== design/ffsa_pkg.sv =====
package ffsa_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int HEADER_BYTES = 16;
	localparam int IDX_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int ENTRY_W = 64;

	// Action codes.
	localparam logic ACT_ALLOCATE = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Configuration register indexes.
	localparam logic REG_HEAP_BASE = 1'b0;
	localparam logic REG_HEAP_LENGTH = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_FIT = 2'd1;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

	typedef struct packed {
		logic action;
		logic [31:0] request_size;
		logic [31:0] release_address;
	} request_t;

	typedef struct packed {
		logic [31:0] payload_address;
		logic [1:0] status;
	} result_t;

endpackage

// ===== design/ffsa_ram.sv =====
module ffsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/first_fit_segment_allocator_top.sv =====
// First-fit segment allocator with coalescing.
// The heap region is kept as an address-ordered table of segments (header
// address and payload size in a RAM, in-use marks in flip-flops).
// Requests: drive request and pulse start while busy is low. The request is
// taken at that edge and busy rises in the next cycle.
// Results: done is high for exactly one cycle with result valid; the receiver
// cannot stall, so it must capture the result in that cycle. busy is low again
// in the cycle that done is high.
// Operation: the table is scanned one entry at a time through the single RAM
// read port, and splits and merges move entries one at a time too. An empty
// table answers in the cycle after the request without raising busy.
// Configuration: write cfg_data to register cfg_index with cfg_we, only while
// busy is low. Any write rebuilds the table into one free segment, or into an
// empty table if the new length is below HEADER_BYTES. busy also reads high
// in a cycle with cfg_we, so no request is taken then.
// Reset: base and length are zero, so the table holds no segment.
module first_fit_segment_allocator_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ffsa_pkg::request_t request,
	output logic done,
	output ffsa_pkg::result_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data
);
	import ffsa_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SC_RD = 11'b00000000010,
		S_SC_CK = 11'b00000000100,
		S_A_DEC = 11'b00000001000,
		S_MV_CK = 11'b00000010000,
		S_MV_WR = 11'b00000100000,
		S_A_SPL = 11'b00001000000,
		S_A_FIN = 11'b00010000000,
		S_R_FRE = 11'b00100000000,
		S_R_MRG = 11'b01000000000,
		S_R_SUC = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [31:0] base_q, length_q;
	logic [CNT_W-1:0] count_q;
	logic [MAX_SEGMENTS-1:0] in_use_q;
	logic action_q, succ_phase_q;
	logic [31:0] req_q, addr_q, cur_start_q, cur_size_q;
	logic [IDX_W-1:0] k_q, i_q;
	logic [CNT_W-1:0] j_q;
	logic done_q;
	result_t result_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [31:0] rd_start, rd_size;
	logic [31:0] new_base, new_length;
	logic [CNT_W-1:0] i_ext;
	logic split_ok, scan_hit;
	logic [31:0] merge_size;

	ffsa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_table (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign rd_start = ram_rdata[63:32];
	assign rd_size = ram_rdata[31:0];
	assign i_ext = CNT_W'(i_q);
	assign new_base = (cfg_index == REG_HEAP_BASE) ? cfg_data : base_q;
	assign new_length = (cfg_index == REG_HEAP_LENGTH) ? cfg_data : length_q;

	// Shared compare and add logic of the sequencer.
	always_comb begin
		if (action_q == ACT_ALLOCATE) begin
			scan_hit = !in_use_q[k_q] && (rd_size > req_q);
		end else begin
			scan_hit = in_use_q[k_q] && ((rd_start + 32'(HEADER_BYTES)) == addr_q);
		end
		split_ok = ({1'b0, cur_size_q} >= ({1'b0, req_q} + 33'(HEADER_BYTES + 1)))
			&& (count_q < CNT_W'(MAX_SEGMENTS));
		merge_size = rd_size + cur_size_q + 32'(HEADER_BYTES);
	end

	// Table RAM port control.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = {cur_start_q, cur_size_q};
		ram_raddr = k_q;
		case (state_q)
			S_IDLE: begin
				ram_we = cfg_we;
				ram_wdata = {new_base, new_length - 32'(HEADER_BYTES)};
			end
			S_MV_CK: begin
				if (action_q == ACT_ALLOCATE) begin
					ram_raddr = IDX_W'(j_q - 1'b1);
				end else begin
					ram_raddr = IDX_W'(j_q + 1'b1);
				end
			end
			S_MV_WR: begin
				ram_we = 1'b1;
				ram_waddr = j_q[IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			S_A_SPL: begin
				ram_we = 1'b1;
				ram_waddr = i_q + 1'b1;
				ram_wdata = {cur_start_q + 32'(HEADER_BYTES) + req_q,
					cur_size_q - req_q - 32'(HEADER_BYTES)};
			end
			S_A_FIN: begin
				ram_we = 1'b1;
				ram_waddr = i_q;
				ram_wdata = {cur_start_q, req_q};
			end
			S_R_FRE: begin
				ram_raddr = i_q - 1'b1;
			end
			S_R_MRG: begin
				ram_we = 1'b1;
				ram_waddr = succ_phase_q ? i_q : i_q - 1'b1;
				ram_wdata = succ_phase_q ? {cur_start_q, merge_size} : {rd_start, merge_size};
			end
			S_R_SUC: begin
				ram_raddr = i_q + 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= '0;
			length_q <= '0;
			count_q <= '0;
			in_use_q <= '0;
			done_q <= 1'b0;
			action_q <= ACT_ALLOCATE;
			succ_phase_q <= 1'b0;
			k_q <= '0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_we) begin
						base_q <= new_base;
						length_q <= new_length;
						in_use_q <= '0;
						count_q <= (new_length >= 32'(HEADER_BYTES)) ? CNT_W'(1) : '0;
					end else if (start) begin
						action_q <= request.action;
						req_q <= request.request_size;
						addr_q <= request.release_address;
						k_q <= '0;
						succ_phase_q <= 1'b0;
						if (count_q == '0) begin
							done_q <= 1'b1;
							result_q.payload_address <= '0;
							result_q.status <= (request.action == ACT_ALLOCATE) ?
								ST_NO_FIT : ST_BAD_RELEASE;
						end else begin
							state_q <= S_SC_RD;
						end
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_CK;
				end
				S_SC_CK: begin
					if (scan_hit) begin
						i_q <= k_q;
						cur_start_q <= rd_start;
						cur_size_q <= rd_size;
						state_q <= (action_q == ACT_ALLOCATE) ? S_A_DEC : S_R_FRE;
					end else if (CNT_W'(k_q) + 1'b1 == count_q) begin
						done_q <= 1'b1;
						result_q.payload_address <= '0;
						result_q.status <= (action_q == ACT_ALLOCATE) ?
							ST_NO_FIT : ST_BAD_RELEASE;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_A_DEC: begin
					if (split_ok) begin
						j_q <= count_q;
						state_q <= S_MV_CK;
					end else begin
						in_use_q[i_q] <= 1'b1;
						done_q <= 1'b1;
						result_q.payload_address <= cur_start_q + 32'(HEADER_BYTES);
						result_q.status <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_MV_CK: begin
					if (action_q == ACT_ALLOCATE) begin
						state_q <= (j_q > i_ext + 1'b1) ? S_MV_WR : S_A_SPL;
					end else if (j_q < count_q) begin
						state_q <= S_MV_WR;
					end else if (!succ_phase_q) begin
						state_q <= S_R_SUC;
					end else begin
						done_q <= 1'b1;
						result_q.payload_address <= '0;
						result_q.status <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_MV_WR: begin
					j_q <= (action_q == ACT_ALLOCATE) ? j_q - 1'b1 : j_q + 1'b1;
					state_q <= S_MV_CK;
				end
				S_A_SPL: begin
					// Open a free slot just above the split segment.
					for (int n = 0; n < MAX_SEGMENTS; n++) begin
						if (CNT_W'(n) > i_ext + 1'b1) begin
							in_use_q[n] <= in_use_q[(n + MAX_SEGMENTS - 1) % MAX_SEGMENTS];
						end else if (CNT_W'(n) == i_ext + 1'b1) begin
							in_use_q[n] <= 1'b0;
						end
					end
					count_q <= count_q + 1'b1;
					state_q <= S_A_FIN;
				end
				S_A_FIN: begin
					in_use_q[i_q] <= 1'b1;
					done_q <= 1'b1;
					result_q.payload_address <= cur_start_q + 32'(HEADER_BYTES);
					result_q.status <= ST_OK;
					state_q <= S_IDLE;
				end
				S_R_FRE: begin
					in_use_q[i_q] <= 1'b0;
					if (i_q != '0 && !in_use_q[i_q - 1'b1]) begin
						state_q <= S_R_MRG;
					end else begin
						state_q <= S_R_SUC;
					end
				end
				S_R_SUC: begin
					if (i_ext + 1'b1 < count_q && !in_use_q[i_q + 1'b1]) begin
						succ_phase_q <= 1'b1;
						state_q <= S_R_MRG;
					end else begin
						done_q <= 1'b1;
						result_q.payload_address <= '0;
						result_q.status <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				S_R_MRG: begin
					// Merge and drop the upper entry of the pair.
					for (int n = 0; n < MAX_SEGMENTS; n++) begin
						if (CNT_W'(n) >= i_ext + CNT_W'(succ_phase_q)) begin
							in_use_q[n] <= (n + 1 < MAX_SEGMENTS) ?
								in_use_q[(n + 1) % MAX_SEGMENTS] : 1'b0;
						end
					end
					count_q <= count_q - 1'b1;
					cur_size_q <= merge_size;
					j_q <= i_ext + CNT_W'(succ_phase_q);
					if (!succ_phase_q) begin
						cur_start_q <= rd_start;
						i_q <= i_q - 1'b1;
					end
					state_q <= S_MV_CK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || cfg_we;
	assign done = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("result strobe while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SEGMENTS))
		else $error("segment count overflow");
	a_marks_below: assert property (@(posedge clk) disable iff (!arst_n)
		(in_use_q >> count_q) == '0)
		else $error("in-use mark beyond segment count");
	a_start_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_we) |=> (busy || done))
		else $error("request accepted without progress");
`endif

endmodule

// ===== tb/first_fit_segment_allocator_checker.sv =====
module first_fit_segment_allocator_checker
	import ffsa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input request_t request,
	input logic done,
	input result_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [31:0] cfg_data,
	output int fail_count,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] base_q;
	logic [31:0] length_q;
	logic [31:0] seg_addr [MAX_SEGMENTS];
	logic [31:0] seg_size [MAX_SEGMENTS];
	logic seg_used [MAX_SEGMENTS];
	int seg_num;
	result_t expected_results[$];

	// Rebuild the table as one free segment covering the region (no segment if it is shorter than a header).
	function automatic void rebuild_table();
		for (int k = 0; k < MAX_SEGMENTS; k++) begin
			seg_used[k] = 1'b0;
		end
		if (length_q < HEADER_BYTES) begin
			seg_num = 0;
		end else begin
			seg_addr[0] = base_q;
			seg_size[0] = length_q - HEADER_BYTES;
			seg_num = 1;
		end
	endfunction

	function automatic void remove_entry(int k);
		for (int j = k; j + 1 < seg_num; j++) begin
			seg_addr[j] = seg_addr[j + 1];
			seg_size[j] = seg_size[j + 1];
			seg_used[j] = seg_used[j + 1];
		end
		seg_num--;
	endfunction

	// Apply one request to the predicted table and return its answer.
	function automatic result_t predict_answer(request_t req);
		result_t r;
		int i;
		logic [32:0] need;
		r.payload_address = '0;
		r.status = ST_OK;
		if (req.action == ACT_ALLOCATE) begin
			for (i = 0; i < seg_num; i++) begin
				if (!seg_used[i] && seg_size[i] > req.request_size) begin
					break;
				end
			end
			if (i >= seg_num) begin
				r.status = ST_NO_FIT;
				return r;
			end
			need = {1'b0, req.request_size} + HEADER_BYTES + 1;
			if ({1'b0, seg_size[i]} >= need && seg_num < MAX_SEGMENTS) begin
				for (int j = seg_num; j > i + 1; j--) begin
					seg_addr[j] = seg_addr[j - 1];
					seg_size[j] = seg_size[j - 1];
					seg_used[j] = seg_used[j - 1];
				end
				seg_addr[i + 1] = seg_addr[i] + HEADER_BYTES + req.request_size;
				seg_size[i + 1] = seg_size[i] - req.request_size - HEADER_BYTES;
				seg_used[i + 1] = 1'b0;
				seg_size[i] = req.request_size;
				seg_num++;
			end
			seg_used[i] = 1'b1;
			r.payload_address = seg_addr[i] + HEADER_BYTES;
		end else begin
			for (i = 0; i < seg_num; i++) begin
				if (seg_used[i] && seg_addr[i] + HEADER_BYTES == req.release_address) begin
					break;
				end
			end
			if (i >= seg_num) begin
				r.status = ST_BAD_RELEASE;
				return r;
			end
			seg_used[i] = 1'b0;
			if (i > 0 && !seg_used[i - 1]) begin
				seg_size[i - 1] = seg_size[i - 1] + seg_size[i] + HEADER_BYTES;
				remove_entry(i);
				i--;
			end
			if (i + 1 < seg_num && !seg_used[i + 1]) begin
				seg_size[i] = seg_size[i] + seg_size[i + 1] + HEADER_BYTES;
				remove_entry(i + 1);
			end
		end
		return r;
	endfunction

	assign pending = expected_results.size();

	// Watch configuration writes, accepted requests and results.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			base_q = '0;
			length_q = '0;
			rebuild_table();
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: addr %h status %0d",
							result.payload_address, result.status);
					end
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r !== result) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result differs: expected addr %h status %0d, got addr %h status %0d",
								exp_r.payload_address, exp_r.status,
								result.payload_address, result.status);
						end
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_HEAP_BASE) begin
					base_q = cfg_data;
				end else begin
					length_q = cfg_data;
				end
				rebuild_table();
			end
			if (start && !busy) begin
				expected_results.push_back(predict_answer(request));
			end
		end
	end
endmodule

// ===== tb/first_fit_segment_allocator_top_tb.sv =====
module first_fit_segment_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ffsa_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_HEAP_BASE;
	logic [31:0] cfg_data = '0;
	int fail_count;
	int pending;
	int cycle_count = 0;
	logic [31:0] handed_out[$];
	logic [31:0] cur_base;

	first_fit_segment_allocator_top uut (.*);

	first_fit_segment_allocator_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("first_fit_segment_allocator_top: mismatch");
			$finish;
		end
	end

	// Issue one request and wait until the block takes it.
	task automatic send_request(logic act, logic [31:0] sz, logic [31:0] addr);
		request_t r;
		r.action = act;
		r.request_size = sz;
		r.release_address = addr;
		@(posedge clk);
		while (busy) @(posedge clk);
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drain();
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
		repeat (4 * MAX_SEGMENTS + 20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_region(logic [31:0] b, logic [31:0] len);
		wait_drain();
		write_reg(REG_HEAP_BASE, b);
		write_reg(REG_HEAP_LENGTH, len);
		cur_base = b;
		handed_out.delete();
	endtask

	function automatic logic [31:0] pick_size(int mode);
		case (mode)
			0: return $urandom_range(0, 64);
			1: return $urandom_range(0, 600);
			2: return $urandom_range(0, 5000);
			default: return $urandom;
		endcase
	endfunction

	// Mostly allocations and releases of live addresses, plus noise.
	task automatic random_phase(int count, int mode);
		int k;
		int gap;
		logic [31:0] a;
		for (int n = 0; n < count; n++) begin
			if (n % 16 == 0 && $urandom_range(0, 2) == 0) begin
				gap = $urandom_range(1, 30);
				repeat (gap) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_request(ACT_ALLOCATE, pick_size(mode), $urandom);
				5, 6, 7: begin
					if (handed_out.size() > 0) begin
						k = $urandom_range(0, handed_out.size() - 1);
						a = handed_out[k];
						handed_out.delete(k);
						send_request(ACT_RELEASE, $urandom, a);
					end else begin
						send_request(ACT_RELEASE, $urandom, $urandom);
					end
				end
				8: send_request(ACT_RELEASE, $urandom,
					cur_base + HEADER_BYTES + $urandom_range(0, 200));
				default: send_request(ACT_RELEASE, $urandom, $urandom);
			endcase
			// Track successful allocations from the answer.
			if (request.action == ACT_ALLOCATE) begin
				while (!done) @(posedge clk);
				#1;
				if (result.status == ST_OK) begin
					handed_out.push_back(result.payload_address);
				end
			end
		end
	endtask

	initial begin
		cur_base = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// Empty region after reset: allocations cannot fit.
		send_request(ACT_ALLOCATE, 32'd0, 32'd0);
		send_request(ACT_RELEASE, 32'hFFFF_FFFF, 32'd16);
		// Too small, exactly a header, then a normal region.
		set_region(32'h1000, HEADER_BYTES - 1);
		send_request(ACT_ALLOCATE, 32'd0, 32'hFFFF_FFFF);
		set_region(32'h1000, HEADER_BYTES);
		send_request(ACT_ALLOCATE, 32'd0, 32'd0);
		set_region(32'h1000, 32'd400);
		send_request(ACT_ALLOCATE, 32'd10, 32'd0);
		send_request(ACT_ALLOCATE, 32'd20, 32'd0);
		send_request(ACT_ALLOCATE, 32'd30, 32'd0);
		send_request(ACT_RELEASE, 32'd0, 32'h1010);
		send_request(ACT_RELEASE, 32'd0, 32'h1010);
		send_request(ACT_RELEASE, 32'd0, 32'h1040);
		send_request(ACT_RELEASE, 32'd0, 32'h1034);
		send_request(ACT_ALLOCATE, 32'hFFFF_FFFF, 32'd0);
		send_request(ACT_ALLOCATE, 32'd383, 32'd0);
		// Address wrap near the top of the space, with a huge length.
		set_region(32'hFFFF_FFF0, 32'hFFFF_FFFF);
		send_request(ACT_ALLOCATE, 32'd0, 32'd0);
		send_request(ACT_ALLOCATE, 32'hFFFF_FF00, 32'd0);
		send_request(ACT_RELEASE, 32'd0, 32'd0);
		send_request(ACT_ALLOCATE, 32'hFFFF_FFFE, 32'd0);
		// Full table: many tiny allocations.
		set_region(32'h8000_0000, 32'd5000);
		random_phase(1, 0);
		for (int n = 0; n < 70; n++) send_request(ACT_ALLOCATE, 32'd1, 32'd0);
		send_request(ACT_ALLOCATE, 32'd1, 32'd0);
		// Random phases across several region settings.
		set_region($urandom, 32'd3000);
		random_phase(300, 0);
		set_region(32'd0, 32'd20000);
		random_phase(300, 1);
		set_region($urandom, $urandom_range(100, 100000));
		random_phase(250, 2);
		set_region($urandom, $urandom);
		random_phase(200, 3);
		set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(120, 2);
		wait_drain();
		if (fail_count == 0 && pending == 0) begin
			$display("first_fit_segment_allocator_top: match");
		end else begin
			$display("first_fit_segment_allocator_top: mismatch");
		end
		$finish;
	end
endmodule
